FILE: rtl/core/pss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

  localparam int unsigned DEF_VOICES          = 16;
  localparam int unsigned DEF_SINE_TABLE_BITS = 10;
  localparam int unsigned DEF_SAMPLE_RATE     = 48000;

  localparam int unsigned CFG_W = 16;

  localparam logic [15:0] ATTACK_RESET  = 16'd66;
  localparam logic [15:0] RELEASE_RESET = 16'd328;
  localparam logic [15:0] TARGET_RESET  = 16'd6554;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_TARGET  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_START    = 2'd1,
    FUNC_END      = 2'd2,
    FUNC_CONTINUE = 2'd3
  } func_e;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [19:0] SAMPLE_MAX = 20'sd524287;
  localparam logic signed [19:0] SAMPLE_MIN = -20'sd524288;

  // Top octave (notes 108 to 119) in Q16 Hz.
  localparam logic [31:0] TOP_OCTAVE_Q16 [12] = '{
    32'd274334289, 32'd290647055, 32'd307929831, 32'd326240288,
    32'd345639545, 32'd366192342, 32'd387967272, 32'd411037005,
    32'd435478539, 32'd461373440, 32'd488808132, 32'd517874176
  };

endpackage

`default_nettype wire

FILE: rtl/core/pss_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pss_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/polyphonic_sine_voice_synth.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                  | Transaction
// ----------+----------------------------------------+------------------------------
// command   | start, busy, func_i, note_i            | start high while busy low
// result    | sample_valid_o, sample_o               | one cycle with strobe high
// config    | cfg_we_i, cfg_idx_i, cfg_data_i        | cfg_we_i high
//
// Note events complete in the cycle they are accepted; busy stays low.
// A tick walks the voices through the phase/level RAM, one voice per cycle, and raises
// the sample strobe once the walk has drained; busy falls with it, so the next transaction
// can be taken while the strobe is high.
// The serial walk feeds the ramp, multiply, accumulate and saturate stages in turn.
// Reset clears the voice flags and control registers and loads the config defaults; the RAM needs no clearing.
// The receiver cannot stall, so the sample is shown for exactly one cycle.

module polyphonic_sine_voice_synth
  import pss_pkg::*;
#(
  parameter int unsigned VOICES          = DEF_VOICES,
  parameter int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
  parameter int unsigned SAMPLE_RATE     = DEF_SAMPLE_RATE
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              func_i,
  input  wire logic [6:0]              note_i,
  output logic                         sample_valid_o,
  output logic signed [19:0]           sample_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [1:0]              cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW    = VW + 1;
  localparam int unsigned TB    = SINE_TABLE_BITS;
  localparam int unsigned QSIZE = 2 ** (TB - 2);
  localparam int unsigned MW    = 48;
  localparam int unsigned PW    = 33;
  localparam int unsigned AW    = PW + VW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;

  logic [15:0] attack_q, release_q, target_q;
  logic [VOICES-1:0] active_q, rel_q;
  logic [6:0] note_q [VOICES];

  // Constant tables.
  logic [14:0] qsine [QSIZE+1];
  logic [31:0] inc_rom [128];

  // Quarter-wave sine in unsigned Q0.15: truncated Taylor series through the thirteenth power.
  for (genvar g = 0; g <= QSIZE; g++) begin : g_qsine
    localparam longint unsigned T  = (64'(g) * HALF_PI_Q30) >> (TB - 2);
    localparam longint unsigned T2 = (T * T) >> 30;
    localparam longint unsigned E1 = ((T * T2) >> 30) / 64'd6;
    localparam longint unsigned E2 = ((E1 * T2) >> 30) / 64'd20;
    localparam longint unsigned E3 = ((E2 * T2) >> 30) / 64'd42;
    localparam longint unsigned E4 = ((E3 * T2) >> 30) / 64'd72;
    localparam longint unsigned E5 = ((E4 * T2) >> 30) / 64'd110;
    localparam longint unsigned E6 = ((E5 * T2) >> 30) / 64'd156;
    localparam longint          SUM = longint'(T - E1 + E2 - E3 + E4 - E5 + E6);
    localparam longint unsigned SC = (SUM < 0) ? 64'd0 : 64'(SUM);
    localparam longint unsigned V  = (SC * 64'd32767 + (64'd1 << 29)) >> 30;
    localparam longint unsigned VC = (V > 64'd32767) ? 64'd32767 : V;
    assign qsine[g] = VC[14:0];
  end
  for (genvar g = 0; g < 128; g++) begin : g_inc
    localparam longint unsigned X   = 64'(TOP_OCTAVE_Q16[g % 12]) << (7 + g / 12);
    localparam longint unsigned INC = (X + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
    assign inc_rom[g] = INC[31:0];
  end

  // Note lookup over the voice flags.
  logic [VOICES-1:0] match_vec;
  logic              match_hit, free_hit;
  logic [VW-1:0]     match_idx, free_idx;

  always_comb begin
    match_hit = 1'b0;
    free_hit  = 1'b0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < VOICES; i++) begin
      match_vec[i] = active_q[i] && (note_q[i] == note_i);
    end
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        match_hit = 1'b1;
        match_idx = VW'(i);
      end
      if (!active_q[i]) begin
        free_hit = 1'b1;
        free_idx = VW'(i);
      end
    end
  end

  logic accept;
  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // Pipeline control.
  logic [CW-1:0] rd_cnt_q;
  logic          s1_v_q, s1_last_q;
  logic [VW-1:0] s1_idx_q;
  logic          s2_v_q, s2_last_q;
  logic          s3_v_q, s3_last_q;
  logic          fin_q;

  logic          issue;
  assign issue = (state_q == ST_RUN) && (rd_cnt_q < CW'(VOICES));

  // RAM holds {phase, level} per voice.
  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata, ram_rdata;

  // Stage one: ramp the level, advance the phase and look up both sines.
  logic [31:0] ph, ph2, ph_next;
  logic [15:0] lvl, lvl_next;
  logic [16:0] lvl_sum;
  logic        keep;
  logic [TB-1:0] k [2];
  logic [TB-3:0] r [2];
  logic [TB-2:0] u [2];
  logic signed [15:0] s [2];
  logic signed [16:0] ssum;

  always_comb begin
    ph       = ram_rdata[47:16];
    lvl      = ram_rdata[15:0];
    ph2      = {ph[30:0], 1'b0};
    keep     = 1'b1;
    lvl_sum  = 17'(lvl) + 17'(attack_q);
    lvl_next = lvl;
    if (rel_q[s1_idx_q]) begin
      if (lvl <= release_q) begin
        lvl_next = '0;
        keep     = 1'b0;
      end else begin
        lvl_next = lvl - release_q;
      end
    end else if (lvl < target_q) begin
      if (lvl_sum > 17'(target_q)) begin
        lvl_next = target_q;
      end else begin
        lvl_next = lvl_sum[15:0];
      end
    end
    ph_next = ph + inc_rom[note_q[s1_idx_q]];

    k[0] = ph[31 -: TB];
    k[1] = ph2[31 -: TB];
    for (int j = 0; j < 2; j++) begin
      r[j] = k[j][TB-3:0];
      u[j] = k[j][TB-2] ? ((TB-1)'(QSIZE) - {1'b0, r[j]}) : {1'b0, r[j]};
      s[j] = k[j][TB-1] ? -$signed({1'b0, qsine[u[j]]}) : $signed({1'b0, qsine[u[j]]});
    end
    ssum = 17'(s[0]) + 17'(s[1]);
  end

  logic voice_live;
  assign voice_live = s1_v_q && active_q[s1_idx_q];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_idx_q;
    ram_wdata = {ph_next, lvl_next};
    if (state_q == ST_RUN) begin
      ram_we = voice_live;
    end else if (accept && (func_e'(func_i) == FUNC_START) && !match_hit && free_hit) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = '0;
    end
  end

  pss_ram #(
    .WIDTH (MW),
    .DEPTH (VOICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[VW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Datapath registers.
  logic signed [16:0]   ssum_q;
  logic        [15:0]   lvl_q;
  logic                 contrib_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] rounded;

  always_ff @(posedge clk_i) begin
    ssum_q    <= ssum;
    lvl_q     <= lvl_next;
    contrib_q <= voice_live && keep;
    prod_q    <= contrib_q ? PW'(ssum_q * $signed({1'b0, lvl_q})) : '0;
    if (accept && (func_e'(func_i) == FUNC_START) && !match_hit && free_hit) begin
      note_q[free_idx] <= note_i;
    end
  end

  assign rounded = (acc_q + AW'(32768)) >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      attack_q       <= ATTACK_RESET;
      release_q      <= RELEASE_RESET;
      target_q       <= TARGET_RESET;
      active_q       <= '0;
      rel_q          <= '0;
      rd_cnt_q       <= '0;
      s1_v_q         <= 1'b0;
      s1_last_q      <= 1'b0;
      s1_idx_q       <= '0;
      s2_v_q         <= 1'b0;
      s2_last_q      <= 1'b0;
      s3_v_q         <= 1'b0;
      s3_last_q      <= 1'b0;
      fin_q          <= 1'b0;
      acc_q          <= '0;
      sample_valid_o <= 1'b0;
      sample_o       <= '0;
    end else begin
      sample_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_ATTACK:  attack_q  <= cfg_data_i;
          REG_RELEASE: release_q <= cfg_data_i;
          REG_TARGET:  target_q  <= cfg_data_i;
          default: ;
        endcase
      end

      s1_v_q    <= issue;
      s1_last_q <= issue && (rd_cnt_q == CW'(VOICES - 1));
      s1_idx_q  <= rd_cnt_q[VW-1:0];
      s2_v_q    <= s1_v_q;
      s2_last_q <= s1_last_q;
      s3_v_q    <= s2_v_q;
      s3_last_q <= s2_last_q;
      fin_q     <= s3_v_q && s3_last_q;
      if (issue) begin
        rd_cnt_q <= rd_cnt_q + CW'(1);
      end
      if (s3_v_q) begin
        acc_q <= acc_q + AW'(prod_q);
      end
      if (voice_live && !keep) begin
        active_q[s1_idx_q] <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (func_e'(func_i))
              FUNC_TICK: begin
                state_q  <= ST_RUN;
                rd_cnt_q <= '0;
                acc_q    <= '0;
              end
              FUNC_START: begin
                if (match_hit) begin
                  rel_q[match_idx] <= 1'b0;
                end else if (free_hit) begin
                  active_q[free_idx] <= 1'b1;
                  rel_q[free_idx]    <= 1'b0;
                end
              end
              FUNC_END: begin
                if (match_hit) begin
                  rel_q[match_idx] <= 1'b1;
                end
              end
              FUNC_CONTINUE: begin
                if (match_hit) begin
                  rel_q[match_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (fin_q) begin
            state_q        <= ST_IDLE;
            sample_valid_o <= 1'b1;
            if (rounded > AW'(SAMPLE_MAX)) begin
              sample_o <= SAMPLE_MAX;
            end else if (rounded < AW'(SAMPLE_MIN)) begin
              sample_o <= SAMPLE_MIN;
            end else begin
              sample_o <= rounded[19:0];
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/polyphonic_sine_voice_synth_checker.sv
`timescale 1ns / 1ps

module polyphonic_sine_voice_synth_checker
  import pss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         func_i,
  input  logic [6:0]         note_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               sample_valid_o,
  input  logic signed [19:0] sample_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int NV = DEF_VOICES;
  localparam int TBITS = DEF_SINE_TABLE_BITS;

  int              sine_tab [1 << TBITS];
  logic [31:0]     note_step [128];

  logic [15:0]     attack_q, release_q, target_q;
  logic            v_on [NV];
  logic            v_rel [NV];
  logic [6:0]      v_note [NV];
  logic [31:0]     v_phase [NV];
  logic [15:0]     v_level [NV];

  logic signed [19:0] samples_due [$];
  int fails;

  assign fail_count_o = fails;

  function automatic int quarter_wave(longint unsigned u);
    longint unsigned t, t2, term, v;
    longint          acc;
    t    = (u * HALF_PI_Q30) / (64'd1 << (TBITS - 2));
    t2   = (t * t) >> 30;
    term = t;
    acc  = longint'(t);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  initial begin
    int quad, r, u;
    longint unsigned x;
    for (int k = 0; k < (1 << TBITS); k++) begin
      quad = k >> (TBITS - 2);
      r    = k & ((1 << (TBITS - 2)) - 1);
      u    = (quad % 2 == 1) ? (1 << (TBITS - 2)) - r : r;
      sine_tab[k] = (quad >= 2) ? -quarter_wave(u) : quarter_wave(u);
    end
    for (int n = 0; n < 128; n++) begin
      x = 64'(TOP_OCTAVE_Q16[n % 12]) << (7 + n / 12);
      x = (x + DEF_SAMPLE_RATE / 2) / DEF_SAMPLE_RATE;
      note_step[n] = x[31:0];
    end
  end

  function automatic int find_note(logic [6:0] n);
    for (int i = 0; i < NV; i++) begin
      if (v_on[i] && v_note[i] == n) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic logic signed [19:0] mix_tick();
    longint          mix;
    longint          res;
    logic [16:0]     lvl;
    logic [31:0]     ph2;
    mix = 0;
    for (int i = 0; i < NV; i++) begin
      if (v_on[i]) begin
        if (v_rel[i]) begin
          if (v_level[i] <= release_q) begin
            v_level[i] = '0;
            v_on[i]    = 1'b0;
          end else begin
            v_level[i] = v_level[i] - release_q;
          end
        end else if (v_level[i] < target_q) begin
          lvl = {1'b0, v_level[i]} + {1'b0, attack_q};
          v_level[i] = (lvl > {1'b0, target_q}) ? target_q : lvl[15:0];
        end
        if (v_on[i]) begin
          ph2 = v_phase[i] << 1;
          mix += longint'(sine_tab[v_phase[i] >> (32 - TBITS)] + sine_tab[ph2 >> (32 - TBITS)])
                 * longint'(v_level[i]);
          v_phase[i] = v_phase[i] + note_step[v_note[i]];
        end
      end
    end
    res = (mix + 32768) >>> 16;
    if (res > SAMPLE_MAX) begin
      res = SAMPLE_MAX;
    end else if (res < SAMPLE_MIN) begin
      res = SAMPLE_MIN;
    end
    return res[19:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int v;
    logic signed [19:0] want;
    if (!rst_ni) begin
      attack_q  = ATTACK_RESET;
      release_q = RELEASE_RESET;
      target_q  = TARGET_RESET;
      for (int i = 0; i < NV; i++) begin
        v_on[i]  = 1'b0;
        v_rel[i] = 1'b0;
      end
      samples_due.delete();
      fails     = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK:  attack_q  = cfg_data_i;
          REG_RELEASE: release_q = cfg_data_i;
          REG_TARGET:  target_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (sample_valid_o) begin
        if (samples_due.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected sample %0d", $realtime, sample_o);
          end
          fails = fails + 1;
        end else begin
          want = samples_due.pop_front();
          if (want !== sample_o) begin
            if (fails < 10) begin
              $display("%0t: sample mismatch, expected %0d, got %0d",
                       $realtime, want, sample_o);
            end
            fails = fails + 1;
          end
        end
      end
      if (start && !busy) begin
        case (func_e'(func_i))
          FUNC_START: begin
            v = find_note(note_i);
            if (v >= 0) begin
              v_rel[v] = 1'b0;
            end else begin
              for (int i = 0; i < NV; i++) begin
                if (!v_on[i] && v < 0) begin
                  v = i;
                end
              end
              if (v >= 0) begin
                v_on[v]    = 1'b1;
                v_rel[v]   = 1'b0;
                v_note[v]  = note_i;
                v_phase[v] = '0;
                v_level[v] = '0;
              end
            end
          end
          FUNC_END: begin
            v = find_note(note_i);
            if (v >= 0) begin
              v_rel[v] = 1'b1;
            end
          end
          FUNC_CONTINUE: begin
            v = find_note(note_i);
            if (v >= 0) begin
              v_rel[v] = 1'b0;
            end
          end
          default: samples_due.push_back(mix_tick());
        endcase
      end
      pending_o = samples_due.size();
    end
  end

endmodule

FILE: bench/polyphonic_sine_voice_synth_tb.sv
`timescale 1ns / 1ps

module polyphonic_sine_voice_synth_tb;
  import pss_pkg::*;

  // The index port is two bits wide; the top value names no register.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i, rst_ni;
  logic               start, busy;
  logic [1:0]         func_i;
  logic [6:0]         note_i;
  logic               sample_valid_o;
  logic signed [19:0] sample_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  int                 fail_count, pending;
  bit                 gaps_on;
  logic [6:0]         held_notes [24];

  polyphonic_sine_voice_synth dut (.*);

  polyphonic_sine_voice_synth_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .func_i, .note_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .sample_valid_o, .sample_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** polyphonic_sine_voice_synth: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] atk, logic [15:0] rel, logic [15:0] tgt);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_TARGET, tgt);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // One command transaction; returns at the falling edge after acceptance.
  task automatic send(func_e f, logic [6:0] n);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start  <= 1'b1;
    func_i <= f;
    note_i <= n;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DEF_VOICES + 10) @(negedge clk_i);
  endtask

  task automatic random_items(int count);
    int pick;
    for (int j = 0; j < 24; j++) begin
      held_notes[j] = 7'($urandom_range(0, 127));
    end
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        send(FUNC_TICK, 7'($urandom));
      end else if (pick < 67) begin
        send(FUNC_START, held_notes[$urandom_range(0, 23)]);
      end else if (pick < 82) begin
        send(FUNC_END, held_notes[$urandom_range(0, 23)]);
      end else if (pick < 92) begin
        send(FUNC_CONTINUE, held_notes[$urandom_range(0, 23)]);
      end else begin
        send(func_e'($urandom_range(0, 3)), 7'($urandom));
      end
    end
    drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    func_i     = FUNC_TICK;
    note_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_ATTACK;
    cfg_data_i = '0;
    gaps_on    = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings first, with a random mix of commands.
    random_items(120);

    // Fast attack, steep release, full target.
    set_regs(16'hFFFF, 16'd20000, 16'hFFFF);
    send(FUNC_START, 7'd0);
    send(FUNC_START, 7'd127);
    send(FUNC_TICK, 7'd0);
    send(FUNC_START, 7'd127);
    send(FUNC_END, 7'd127);
    send(FUNC_END, 7'd5);
    send(FUNC_CONTINUE, 7'd6);
    send(FUNC_TICK, 7'd0);
    send(FUNC_CONTINUE, 7'd127);
    send(FUNC_END, 7'd0);
    repeat (5) send(FUNC_TICK, 7'd0);
    for (int n = 60; n < 77; n++) begin
      send(FUNC_START, 7'(n));
    end
    send(FUNC_TICK, 7'd0);
    drain();

    // Target below the current levels: voices must hold above it.
    write_reg(REG_UNUSED, 16'hFFFF);
    set_regs(16'd0, 16'hFFFF, 16'd100);
    random_items(150);

    set_regs(16'd1, 16'd1, 16'hFFFF);
    random_items(150);

    set_regs(16'hFFFF, 16'd0, 16'hFFFF);
    random_items(150);

    set_regs(16'($urandom), 16'($urandom), 16'($urandom));
    random_items(150);

    gaps_on = 1'b0;
    set_regs(16'd3000, 16'd900, 16'd40000);
    random_items(200);

    if (fail_count == 0 && pending == 0) begin
      $display("** polyphonic_sine_voice_synth: PASSED **");
    end else begin
      $display("** polyphonic_sine_voice_synth: FAILED **");
    end
    $finish;
  end

endmodule
